[sv/adll_pkg.sv]
`default_nettype none

package adll_pkg;

  // Fixed field widths of the words on the two channels
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LINK_W   = 8;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes as they arrive on the input channel
  localparam logic [KIND_W-1:0] KIND_ALLOC      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_VALUE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_NEXT  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_PREV  = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // Classified operation
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_INSERT,
    OP_DELETE,
    OP_READ_VALUE,
    OP_READ_NEXT,
    OP_READ_PREV,
    OP_BAD
  } op_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BS_INIT,
    BS_IDLE,
    BS_CHECK,
    BS_FINISH
  } back_state_e;

  // One classified command
  typedef struct packed {
    op_e               op;
    logic              pos_ok;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_flags_t;

  typedef struct packed {
    logic init_done;
  } back_flags_t;

endpackage

`default_nettype wire

[sv/adll_if.sv]
`default_nettype none

interface adll_in_if;
  import adll_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] new_value;

  modport source (output valid, output kind, output position, output new_value,
                  input ready);
  modport sink (input valid, input kind, input position, input new_value,
                output ready);
endinterface

interface adll_out_if;
  import adll_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LINK_W-1:0]   link_out;
  logic                link_none;
  logic [DATA_W-1:0]   value_out;

  modport source (output valid, output status, output link_out, output link_none,
                  output value_out, input ready);
  modport sink (input valid, input status, input link_out, input link_none,
                input value_out, output ready);
endinterface

`default_nettype wire

[sv/adll_ram.sv]
`default_nettype none

module adll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word; a read hits the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/adll_front.sv]
`default_nettype none

module adll_front #(
  parameter int unsigned CAPACITY = 256
) (
  adll_in_if.sink                   item_i,
  input  wire adll_pkg::queue_flags_t q_flags_i,
  input  wire adll_pkg::back_flags_t  back_flags_i,
  output logic                      push_o,
  output adll_pkg::cmd_t            cmd_o
);
  import adll_pkg::*;

  op_e  op;
  logic pos_ok;

  // Take a word when the queue has room and the store is initialized
  assign item_i.ready = !q_flags_i.full && back_flags_i.init_done;
  assign push_o       = item_i.valid && item_i.ready;

  // Classify the operation code
  always_comb begin
    unique case (item_i.kind)
      KIND_ALLOC:      op = OP_ALLOC;
      KIND_INSERT:     op = OP_INSERT;
      KIND_DELETE:     op = OP_DELETE;
      KIND_READ_VALUE: op = OP_READ_VALUE;
      KIND_READ_NEXT:  op = OP_READ_NEXT;
      KIND_READ_PREV:  op = OP_READ_PREV;
      default:         op = OP_BAD;
    endcase
  end

  // Flag positions beyond the store
  assign pos_ok = 32'(item_i.position) < 32'(CAPACITY);

  assign cmd_o.op     = op;
  assign cmd_o.pos_ok = pos_ok;
  assign cmd_o.pos    = item_i.position;
  assign cmd_o.value  = item_i.new_value;

endmodule

`default_nettype wire

[sv/adll_queue.sv]
`default_nettype none

module adll_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire adll_pkg::cmd_t         cmd_i,
  input  wire logic                   pop_i,
  output adll_pkg::cmd_t              cmd_o,
  output adll_pkg::queue_flags_t      flags_o
);
  import adll_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o         = slot_q[rd_ptr_q];
  assign flags_o.full  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign flags_o.empty = count_q == '0;

endmodule

`default_nettype wire

[sv/adll_back.sv]
`default_nettype none

module adll_back #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire adll_pkg::cmd_t         cmd_i,
  input  wire adll_pkg::queue_flags_t q_flags_i,
  output logic                        pop_o,
  output adll_pkg::back_flags_t       flags_o,
  adll_out_if.source                  result_o
);
  import adll_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  back_state_e state_q, state_d;
  logic [IDX_W-1:0] init_idx_q, init_idx_d;
  logic [IDX_W-1:0] free_head_q, free_head_d;
  logic             free_empty_q, free_empty_d;
  logic [IDX_W-1:0] used_q, used_d;

  cmd_t             cmd_q, cmd_d;
  logic [IDX_W-1:0] nx_q, nx_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [LINK_W-1:0]   res_link_q, res_link_d;
  logic                res_none_q, res_none_d;
  logic [DATA_W-1:0]   res_value_q, res_value_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [LINK_W-1:0]   out_link_q;
  logic                out_none_q;
  logic [DATA_W-1:0]   out_value_q;
  logic                out_load;

  // Memory ports
  logic                   look_re;
  logic [IDX_W-1:0]       look_addr;
  logic                   val_we;
  logic [IDX_W-1:0]       val_waddr;
  logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;
  logic                   prv_we;
  logic [IDX_W-1:0]       prv_waddr, prv_wdata, prv_rdata;
  logic                   use_we;
  logic [IDX_W-1:0]       use_waddr;
  logic                   use_wdata, use_rdata;
  logic                   nxt_we, nxt_re;
  logic [IDX_W-1:0]       nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;

  logic [IDX_W-1:0] idx;
  logic             readable;
  logic             insert_ok;
  logic             fin_go;
  logic             done_ok;

  adll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i, .we_i(val_we), .waddr_i(val_waddr), .wdata_i(val_wdata),
    .re_i(look_re), .raddr_i(look_addr), .rdata_o(val_rdata)
  );

  adll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prv_ram (
    .clk_i, .we_i(prv_we), .waddr_i(prv_waddr), .wdata_i(prv_wdata),
    .re_i(look_re), .raddr_i(look_addr), .rdata_o(prv_rdata)
  );

  adll_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_use_ram (
    .clk_i, .we_i(use_we), .waddr_i(use_waddr), .wdata_i(use_wdata),
    .re_i(look_re), .raddr_i(look_addr), .rdata_o(use_rdata)
  );

  adll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_nxt_ram (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .re_i(nxt_re), .raddr_i(nxt_raddr), .rdata_o(nxt_rdata)
  );

  // Checks on the looked-up entry
  assign idx       = IDX_W'(cmd_q.pos);
  assign readable  = cmd_q.pos_ok && (idx != '0) && use_rdata;
  assign insert_ok = cmd_q.pos_ok && use_rdata;
  assign fin_go    = !out_valid_q || result_o.ready;
  assign done_ok   = res_status_q == STATUS_OK;
  assign look_addr = IDX_W'(cmd_i.pos);

  // Sequencer: clear, look up, check and first writes, finish
  always_comb begin
    state_d      = state_q;
    init_idx_d   = init_idx_q;
    free_head_d  = free_head_q;
    free_empty_d = free_empty_q;
    used_d       = used_q;
    cmd_d        = cmd_q;
    nx_d         = nx_q;
    res_status_d = res_status_q;
    res_link_d   = res_link_q;
    res_none_d   = res_none_q;
    res_value_d  = res_value_q;
    out_load     = 1'b0;
    pop_o        = 1'b0;
    look_re      = 1'b0;
    val_we       = 1'b0;
    val_waddr    = '0;
    val_wdata    = '0;
    prv_we       = 1'b0;
    prv_waddr    = '0;
    prv_wdata    = '0;
    use_we       = 1'b0;
    use_waddr    = '0;
    use_wdata    = 1'b0;
    nxt_we       = 1'b0;
    nxt_waddr    = '0;
    nxt_wdata    = '0;
    nxt_re       = 1'b0;
    nxt_raddr    = '0;

    unique case (state_q)
      BS_INIT: begin
        val_we    = 1'b1;
        val_waddr = init_idx_q;
        prv_we    = 1'b1;
        prv_waddr = init_idx_q;
        use_we    = 1'b1;
        use_waddr = init_idx_q;
        use_wdata = init_idx_q == '0;
        nxt_we    = 1'b1;
        nxt_waddr = init_idx_q;
        nxt_wdata = (init_idx_q == '0 || init_idx_q == LAST_IDX) ? '0
                    : init_idx_q + IDX_W'(1);
        if (init_idx_q == LAST_IDX) begin
          state_d = BS_IDLE;
        end else begin
          init_idx_d = init_idx_q + IDX_W'(1);
        end
      end

      BS_IDLE: begin
        if (!q_flags_i.empty) begin
          pop_o     = 1'b1;
          cmd_d     = cmd_i;
          look_re   = 1'b1;
          nxt_re    = 1'b1;
          nxt_raddr = look_addr;
          state_d   = BS_CHECK;
        end
      end

      BS_CHECK: begin
        res_status_d = STATUS_OK;
        res_link_d   = '0;
        res_none_d   = 1'b0;
        res_value_d  = '0;
        state_d      = BS_FINISH;
        unique case (cmd_q.op)
          OP_ALLOC: begin
            if (free_empty_q) begin
              res_status_d = STATUS_FULL;
            end else begin
              res_link_d = LINK_W'(free_head_q);
              nxt_re     = 1'b1;
              nxt_raddr  = free_head_q;
              val_we     = 1'b1;
              val_waddr  = free_head_q;
              val_wdata  = VALUE_WIDTH'(cmd_q.value);
              prv_we     = 1'b1;
              prv_waddr  = free_head_q;
              use_we     = 1'b1;
              use_waddr  = free_head_q;
              use_wdata  = 1'b1;
              nxt_we     = 1'b1;
              nxt_waddr  = free_head_q;
            end
          end
          OP_INSERT: begin
            if (!insert_ok) begin
              res_status_d = STATUS_BAD_INDEX;
            end else if (free_empty_q) begin
              res_status_d = STATUS_FULL;
            end else begin
              res_link_d = LINK_W'(free_head_q);
              nx_d       = nxt_rdata;
              nxt_re     = 1'b1;
              nxt_raddr  = free_head_q;
              val_we     = 1'b1;
              val_waddr  = free_head_q;
              val_wdata  = VALUE_WIDTH'(cmd_q.value);
              prv_we     = 1'b1;
              prv_waddr  = free_head_q;
              prv_wdata  = idx;
              use_we     = 1'b1;
              use_waddr  = free_head_q;
              use_wdata  = 1'b1;
              nxt_we     = 1'b1;
              nxt_waddr  = idx;
              nxt_wdata  = free_head_q;
            end
          end
          OP_DELETE: begin
            if (!readable) begin
              res_status_d = STATUS_BAD_INDEX;
            end else begin
              // Unlink from both neighbors, clear value and in-use
              nxt_we    = 1'b1;
              nxt_waddr = prv_rdata;
              nxt_wdata = nxt_rdata;
              prv_we    = 1'b1;
              prv_waddr = nxt_rdata;
              prv_wdata = prv_rdata;
              val_we    = 1'b1;
              val_waddr = idx;
              use_we    = 1'b1;
              use_waddr = idx;
            end
          end
          OP_READ_VALUE: begin
            if (readable) begin
              res_value_d = DATA_W'(val_rdata);
            end else begin
              res_status_d = STATUS_BAD_INDEX;
            end
          end
          OP_READ_NEXT: begin
            if (readable) begin
              res_link_d = LINK_W'(nxt_rdata);
            end else begin
              res_status_d = STATUS_BAD_INDEX;
              res_none_d   = 1'b1;
            end
          end
          OP_READ_PREV: begin
            if (readable) begin
              res_link_d = LINK_W'(prv_rdata);
            end else begin
              res_status_d = STATUS_BAD_INDEX;
              res_none_d   = 1'b1;
            end
          end
          default: begin
            res_status_d = STATUS_BAD_INDEX;
          end
        endcase
      end

      BS_FINISH: begin
        if (fin_go) begin
          out_load = 1'b1;
          state_d  = BS_IDLE;
          if (done_ok) begin
            unique case (cmd_q.op)
              OP_ALLOC: begin
                free_head_d  = nxt_rdata;
                used_d       = used_q + IDX_W'(1);
                free_empty_d = used_d == LAST_IDX;
              end
              OP_INSERT: begin
                nxt_we       = 1'b1;
                nxt_waddr    = free_head_q;
                nxt_wdata    = nx_q;
                prv_we       = 1'b1;
                prv_waddr    = nx_q;
                prv_wdata    = free_head_q;
                free_head_d  = nxt_rdata;
                used_d       = used_q + IDX_W'(1);
                free_empty_d = used_d == LAST_IDX;
              end
              OP_DELETE: begin
                // Push the entry onto the free chain
                nxt_we       = 1'b1;
                nxt_waddr    = idx;
                nxt_wdata    = free_empty_q ? '0 : free_head_q;
                prv_we       = 1'b1;
                prv_waddr    = idx;
                free_head_d  = idx;
                free_empty_d = 1'b0;
                if (used_q != '0) begin
                  used_d = used_q - IDX_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      default: begin
        state_d = BS_INIT;
      end
    endcase
  end

  // Output word register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BS_INIT;
      init_idx_q   <= '0;
      free_head_q  <= IDX_W'(1);
      free_empty_q <= 1'b0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_idx_q   <= init_idx_d;
      free_head_q  <= free_head_d;
      free_empty_q <= free_empty_d;
      used_q       <= used_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    nx_q         <= nx_d;
    res_status_q <= res_status_d;
    res_link_q   <= res_link_d;
    res_none_q   <= res_none_d;
    res_value_q  <= res_value_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_link_q   <= res_link_q;
      out_none_q   <= res_none_q;
      out_value_q  <= res_value_q;
    end
  end

  assign flags_o.init_done  = state_q != BS_INIT;
  assign result_o.valid     = out_valid_q;
  assign result_o.status    = out_status_q;
  assign result_o.link_out  = out_link_q;
  assign result_o.link_none = out_none_q;
  assign result_o.value_out = out_value_q;

  // Free chain is empty exactly when the store is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_empty_q == (used_q == LAST_IDX))
    else $error("free chain flag disagrees with use count");

  // A new result only comes out of the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == BS_FINISH))
    else $error("result raised outside the finish step");

  // A popped command is checked in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == BS_CHECK)
    else $error("popped command not checked");

  // No command leaves the queue and no result is raised during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BS_INIT |-> !pop_o && !out_valid_q)
    else $error("activity during clearing pass");

endmodule

`default_nettype wire

[sv/array_doubly_linked_list.sv]
`default_nettype none

// A taken word waits in the command queue, then passes the look-up, check and
// finish steps around the link memory's single read port, longer when the result
// port stalls. The back end starts a word only once the last has left them.
// Reset: after rst_ni rises, a clearing pass over all CAPACITY entries sets up the
// store (next links chained, sentinel in use); no input word is taken during it.
module array_doubly_linked_list #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  adll_in_if.sink    item_i,
  adll_out_if.source result_o
);
  import adll_pkg::*;

  logic         push;
  logic         pop;
  cmd_t         front_cmd;
  cmd_t         head_cmd;
  queue_flags_t q_flags;
  back_flags_t  back_flags;

  adll_front #(.CAPACITY(CAPACITY)) u_front (
    .item_i       (item_i),
    .q_flags_i    (q_flags),
    .back_flags_i (back_flags),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  adll_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .flags_o (q_flags)
  );

  adll_back #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (head_cmd),
    .q_flags_i (q_flags),
    .pop_o     (pop),
    .flags_o   (back_flags),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
  import adll_pkg::*;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 20;

  // Kinds with no operation behind them
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
  } command_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [LINK_W-1:0]   link;
    logic                none;
    logic [DATA_W-1:0]   value;
  } reply_t;

  // Shadow copy of the list store; predicts one reply per accepted command word
  class list_model;
    logic [DATA_W-1:0] vals[CAPACITY];
    logic [LINK_W-1:0] nxt[CAPACITY];
    logic [LINK_W-1:0] prv[CAPACITY];
    bit                used[CAPACITY];
    logic [LINK_W-1:0] free_head;
    bit                free_empty;
    int unsigned       used_count;
    reply_t            expected_replies[$];
    int unsigned       mismatches;
    int unsigned       kind_seen[8];
    int unsigned       full_replies;
    int unsigned       bad_replies;
    int unsigned       replies_checked;

    function new();
      for (int i = 0; i < CAPACITY; i++) begin
        vals[i] = '0;
        nxt[i]  = (i + 1 < CAPACITY) ? LINK_W'(i + 1) : '0;
        prv[i]  = '0;
        used[i] = 1'b0;
      end
      nxt[0]          = '0;
      used[0]         = 1'b1;
      free_head       = LINK_W'(1);
      free_empty      = 1'b0;
      used_count      = 0;
      mismatches      = 0;
      full_replies    = 0;
      bad_replies     = 0;
      replies_checked = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    // Readable: not the sentinel and in use
    function bit readable(logic [POS_W-1:0] pos);
      return pos != 0 && used[pos];
    endfunction

    function void take_free();
      used_count++;
      if (used_count >= CAPACITY - 1) free_empty = 1'b1;
    endfunction

    // Update the shadow store and queue the reply the word should produce
    function void note_command(command_t cmd);
      reply_t            r;
      logic [LINK_W-1:0] f;
      logic [LINK_W-1:0] nf;
      logic [LINK_W-1:0] nx;
      logic [LINK_W-1:0] p;
      r = '{status: STATUS_OK, link: '0, none: 1'b0, value: '0};
      kind_seen[cmd.kind]++;
      case (cmd.kind)
        KIND_ALLOC: begin
          if (free_empty) begin
            r.status = STATUS_FULL;
          end else begin
            f       = free_head;
            nf      = nxt[f];
            vals[f] = cmd.val;
            prv[f]  = '0;
            nxt[f]  = '0;
            used[f] = 1'b1;
            free_head = nf;
            take_free();
            r.link = f;
          end
        end
        KIND_INSERT: begin
          if (!used[cmd.pos]) begin
            r.status = STATUS_BAD_INDEX;
          end else if (free_empty) begin
            r.status = STATUS_FULL;
          end else begin
            f            = free_head;
            nf           = nxt[f];
            vals[f]      = cmd.val;
            prv[f]       = cmd.pos;
            used[f]      = 1'b1;
            nx           = nxt[cmd.pos];
            nxt[cmd.pos] = f;
            prv[nx]      = f;
            nxt[f]       = nx;
            free_head    = nf;
            take_free();
            r.link = f;
          end
        end
        KIND_DELETE: begin
          if (!readable(cmd.pos)) begin
            r.status = STATUS_BAD_INDEX;
          end else begin
            p             = prv[cmd.pos];
            nx            = nxt[cmd.pos];
            nxt[p]        = nx;
            prv[nx]       = p;
            vals[cmd.pos] = '0;
            prv[cmd.pos]  = '0;
            used[cmd.pos] = 1'b0;
            nxt[cmd.pos]  = free_empty ? '0 : free_head;
            free_head     = cmd.pos;
            free_empty    = 1'b0;
            if (used_count > 0) used_count--;
          end
        end
        KIND_READ_VALUE: begin
          if (!readable(cmd.pos)) r.status = STATUS_BAD_INDEX;
          else r.value = vals[cmd.pos];
        end
        KIND_READ_NEXT, KIND_READ_PREV: begin
          if (!readable(cmd.pos)) begin
            r.status = STATUS_BAD_INDEX;
            r.none   = 1'b1;
          end else begin
            r.link = (cmd.kind == KIND_READ_NEXT) ? nxt[cmd.pos] : prv[cmd.pos];
          end
        end
        default: r.status = STATUS_BAD_INDEX;
      endcase
      if (r.status == STATUS_FULL) full_replies++;
      if (r.status == STATUS_BAD_INDEX) bad_replies++;
      expected_replies.push_back(r);
    endfunction

    // Compare one reply word with the oldest prediction
    function void check_reply(reply_t got);
      reply_t exp_r;
      if (expected_replies.size() == 0) begin
        $error("reply with no command outstanding: status %0d link %0d", got.status,
               got.link);
        mismatches++;
        return;
      end
      exp_r = expected_replies.pop_front();
      replies_checked++;
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        mismatches++;
      end
      if (got.link !== exp_r.link) begin
        $error("link_out: expected %0d, got %0d", exp_r.link, got.link);
        mismatches++;
      end
      if (got.none !== exp_r.none) begin
        $error("link_none: expected %0d, got %0d", exp_r.none, got.none);
        mismatches++;
      end
      if (got.value !== exp_r.value) begin
        $error("value_out: expected %h, got %h", exp_r.value, got.value);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_replies.size();
    endfunction

    // Pick a random entry in use; the sentinel only when asked for
    function void pick_used(bit with_sentinel, output logic [POS_W-1:0] idx,
                            output bit found);
      int unsigned n;
      int unsigned k;
      n     = 0;
      found = 1'b0;
      idx   = '0;
      for (int i = with_sentinel ? 0 : 1; i < CAPACITY; i++) if (used[i]) n++;
      if (n == 0) return;
      k = $urandom_range(n - 1);
      for (int i = with_sentinel ? 0 : 1; i < CAPACITY; i++) begin
        if (used[i]) begin
          if (k == 0 && !found) begin
            idx   = POS_W'(i);
            found = 1'b1;
          end
          if (k > 0) k--;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  adll_in_if  item_if ();
  adll_out_if result_if ();

  array_doubly_linked_list #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  list_model   store_model;
  int unsigned cycle_count;
  int unsigned words_sent;
  bit          sink_quiet;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // Drive one command word and wait for it to be taken
  task automatic send_word(command_t cmd, int unsigned gap);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.kind      <= cmd.kind;
    item_if.position  <= cmd.pos;
    item_if.new_value <= cmd.val;
    do @(posedge clk_i); while (!item_if.ready);
    store_model.note_command(cmd);
    words_sent++;
  endtask

  task automatic send_cmd(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                          logic [DATA_W-1:0] val);
    command_t cmd;
    cmd = '{kind: kind, pos: pos, val: val};
    send_word(cmd, gap_len());
  endtask

  // Build a random command; grow and drop set the share of alloc/insert and delete
  function automatic command_t make_cmd(int unsigned grow_pct, int unsigned drop_pct);
    command_t          cmd;
    int unsigned       r;
    bit                found;
    logic [POS_W-1:0]  idx;
    r       = $urandom_range(99);
    cmd.val = pick_value();
    if (r < 3) cmd.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    else if (r < 3 + grow_pct / 3) cmd.kind = KIND_ALLOC;
    else if (r < 3 + grow_pct) cmd.kind = KIND_INSERT;
    else if (r < 3 + grow_pct + drop_pct) cmd.kind = KIND_DELETE;
    else cmd.kind = KIND_W'($urandom_range(5, 3));
    store_model.pick_used(cmd.kind == KIND_INSERT, idx, found);
    if (!found || $urandom_range(9) == 0) cmd.pos = POS_W'($urandom_range(255));
    else cmd.pos = idx;
    return cmd;
  endfunction

  // Result side back-pressure, with quiet stretches
  int unsigned stall_left;
  always @(posedge clk_i) begin
    sink_quiet = ((cycle_count / 600) % 4) == 3;
    if (stall_left > 0) begin
      stall_left       <= stall_left - 1;
      result_if.ready  <= 1'b0;
    end else if (!sink_quiet && $urandom_range(3) == 0) begin
      stall_left       <= gap_len();
      result_if.ready  <= 1'b0;
    end else begin
      result_if.ready  <= 1'b1;
    end
  end

  // Check every reply word taken
  always @(posedge clk_i) begin
    reply_t got;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = '{status: result_if.status, link: result_if.link_out,
              none: result_if.link_none, value: result_if.value_out};
      store_model.check_reply(got);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    command_t    cmd;
    int unsigned n;
    store_model       = new();
    words_sent        = 0;
    rst_ni            = 1'b0;
    item_if.valid     = 1'b0;
    item_if.kind      = '0;
    item_if.position  = '0;
    item_if.new_value = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bad indices on an empty store
    send_cmd(KIND_READ_VALUE, 8'd0, '0);
    send_cmd(KIND_READ_NEXT, 8'd0, '0);
    send_cmd(KIND_READ_PREV, 8'd0, '0);
    send_cmd(KIND_DELETE, 8'd0, '0);
    send_cmd(KIND_READ_VALUE, 8'd255, '0);
    send_cmd(KIND_INSERT, 8'd7, 32'h1111_1111);
    // Build a short list after the sentinel plus one detached entry
    send_cmd(KIND_ALLOC, 8'd0, '1);
    send_cmd(KIND_INSERT, 8'd0, '0);
    send_cmd(KIND_INSERT, 8'd2, 32'hA5A5_A5A5);
    send_cmd(KIND_READ_VALUE, 8'd1, '0);
    send_cmd(KIND_READ_NEXT, 8'd2, '0);
    send_cmd(KIND_READ_PREV, 8'd3, '0);
    send_cmd(KIND_READ_NEXT, 8'd1, '0);
    // Unused kinds
    send_cmd(KIND_SPARE_LO, 8'd1, '1);
    send_cmd(KIND_SPARE_HI, 8'd255, '1);
    // Delete the detached entry: sentinel links collapse to zero
    send_cmd(KIND_DELETE, 8'd1, '0);
    send_cmd(KIND_READ_NEXT, 8'd2, '0);
    send_cmd(KIND_READ_PREV, 8'd2, '0);
    send_cmd(KIND_DELETE, 8'd3, '0);
    send_cmd(KIND_ALLOC, 8'd255, 32'h1234_5678);
    send_cmd(KIND_INSERT, 8'd255, 32'h5A5A_5A5A);
    send_cmd(KIND_DELETE, 8'd2, '0);
    send_cmd(KIND_READ_VALUE, 8'd2, '0);

    // Random: mixed traffic
    for (n = 0; n < 60; n++) begin
      cmd = make_cmd(35, 25);
      send_word(cmd, ((n / 40) % 3 == 2) ? 0 : gap_len());
    end
    // Random: grow until the store fills, then keep pushing against full
    n = 0;
    while (n < 400) begin
      cmd = make_cmd(80, 5);
      send_word(cmd, ((n / 40) % 3 == 2) ? 0 : gap_len());
      n++;
      if (store_model.free_empty && n < 385) n = 385;
    end
    // Random: drain
    for (n = 0; n < 60; n++) begin
      cmd = make_cmd(15, 55);
      send_word(cmd, ((n / 40) % 3 == 2) ? 0 : gap_len());
    end
    item_if.valid <= 1'b0;

    // Wait out outstanding replies, then let the bench settle
    while (store_model.outstanding() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d words: alloc %0d, insert %0d, delete %0d, reads %0d, unused kinds %0d",
             words_sent, store_model.kind_seen[KIND_ALLOC],
             store_model.kind_seen[KIND_INSERT], store_model.kind_seen[KIND_DELETE],
             store_model.kind_seen[KIND_READ_VALUE] + store_model.kind_seen[KIND_READ_NEXT]
             + store_model.kind_seen[KIND_READ_PREV],
             store_model.kind_seen[KIND_SPARE_LO] + store_model.kind_seen[KIND_SPARE_HI]);
    $display("Checked %0d replies, %0d store-full and %0d bad-index among them",
             store_model.replies_checked, store_model.full_replies,
             store_model.bad_replies);
    if (store_model.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/adll_pkg.sv
sv/adll_if.sv
sv/adll_ram.sv
sv/adll_front.sv
sv/adll_queue.sv
sv/adll_back.sv
sv/array_doubly_linked_list.sv
tb/testbench.sv
